// ===== rtl/vnorm_pkg.sv =====
// shared types and constants for the vector normalization pipeline
`default_nettype none
package vnorm_pkg;

  localparam int CompW     = 16;
  localparam int SumW      = 32;
  localparam int RootW     = 16;
  localparam int UnitShift = 14;
  localparam int QuotW     = UnitShift + 1;
  localparam int RemW      = RootW + UnitShift;
  localparam int Lanes     = 3;

  // input transfer payload
  typedef struct packed {
    logic signed [CompW-1:0] comp_x;
    logic signed [CompW-1:0] comp_y;
    logic signed [CompW-1:0] comp_z;
  } vn_in_t;

  // output transfer payload
  typedef struct packed {
    logic        [RootW-1:0] length;
    logic signed [CompW-1:0] unit_x;
    logic signed [CompW-1:0] unit_y;
    logic signed [CompW-1:0] unit_z;
    logic                    was_zero;
  } vn_out_t;

  // component magnitudes and signs riding along the pipeline
  typedef struct packed {
    logic [Lanes-1:0]            neg;
    logic [Lanes-1:0][CompW-1:0] mag;
  } vn_side_t;

endpackage
`default_nettype wire

// ===== rtl/vnorm_sqrt.sv =====
// pipelined floor square root, one root bit per stage
`default_nettype none
module vnorm_sqrt (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     en_i,
  input  wire logic                     valid_i,
  input  wire logic [vnorm_pkg::SumW-1:0]  sum_i,
  input  wire vnorm_pkg::vn_side_t      side_i,
  output logic                          valid_o,
  output logic [vnorm_pkg::RootW-1:0]   root_o,
  output vnorm_pkg::vn_side_t           side_o
);
  import vnorm_pkg::*;

  localparam int SqW = SumW + 2;

  logic [RootW-1:0]            vld_q;
  logic [RootW-1:0][SumW-1:0]  n_q;
  logic [RootW-1:0][RootW-1:0] root_q;
  logic [RootW-1:0][SumW-1:0]  sq_q;
  vn_side_t [RootW-1:0]        side_q;

  for (genvar k = 0; k < RootW; k++) begin : g_stage
    localparam int Bit = RootW - 1 - k;
    logic             vld_in;
    logic [SumW-1:0]  n_in;
    logic [RootW-1:0] root_in;
    logic [SumW-1:0]  sq_in;
    vn_side_t         side_in;
    logic [SqW-1:0]   cand_sq;
    logic             take;

    // stage inputs
    if (k == 0) begin : g_first
      assign vld_in  = valid_i;
      assign n_in    = sum_i;
      assign root_in = '0;
      assign sq_in   = '0;
      assign side_in = side_i;
    end else begin : g_next
      assign vld_in  = vld_q[k-1];
      assign n_in    = n_q[k-1];
      assign root_in = root_q[k-1];
      assign sq_in   = sq_q[k-1];
      assign side_in = side_q[k-1];
    end

    // (root + 2^b)^2 = root^2 + root*2^(b+1) + 2^(2b)
    assign cand_sq = SqW'(sq_in) + (SqW'(root_in) << (Bit + 1)) + (SqW'(1) << (2 * Bit));
    assign take    = cand_sq <= SqW'(n_in);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        n_q[k]    <= n_in;
        side_q[k] <= side_in;
        if (take) begin
          root_q[k] <= root_in | (RootW'(1) << Bit);
          sq_q[k]   <= SumW'(cand_sq);
        end else begin
          root_q[k] <= root_in;
          sq_q[k]   <= sq_in;
        end
      end
    end
  end

  assign valid_o = vld_q[RootW-1];
  assign root_o  = root_q[RootW-1];
  assign side_o  = side_q[RootW-1];

endmodule
`default_nettype wire

// ===== rtl/vnorm_div.sv =====
// pipelined restoring divider, three lanes, one quotient bit per stage
`default_nettype none
module vnorm_div (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     en_i,
  input  wire logic                     valid_i,
  input  wire logic [vnorm_pkg::RootW-1:0] len_i,
  input  wire vnorm_pkg::vn_side_t      side_i,
  output logic                          valid_o,
  output logic [vnorm_pkg::RootW-1:0]   len_o,
  output logic [vnorm_pkg::Lanes-1:0]   neg_o,
  output logic [vnorm_pkg::Lanes-1:0][vnorm_pkg::QuotW-1:0] quot_o
);
  import vnorm_pkg::*;

  logic [QuotW-1:0]                        vld_q;
  logic [QuotW-1:0][RootW-1:0]             len_q;
  logic [QuotW-1:0][Lanes-1:0]             neg_q;
  logic [QuotW-1:0][Lanes-1:0][RemW-1:0]   rem_q;
  logic [QuotW-1:0][Lanes-1:0][QuotW-1:0]  quot_q;

  for (genvar k = 0; k < QuotW; k++) begin : g_stage
    localparam int Bit = QuotW - 1 - k;
    logic                        vld_in;
    logic [RootW-1:0]            len_in;
    logic [Lanes-1:0]            neg_in;
    logic [Lanes-1:0][RemW-1:0]  rem_in;
    logic [Lanes-1:0][QuotW-1:0] quot_in;
    logic [RemW-1:0]             dsor;

    // stage inputs, dividend is magnitude shifted left by UnitShift, quotient in Q1.14
    if (k == 0) begin : g_first
      assign vld_in = valid_i;
      assign len_in = len_i;
      assign neg_in = side_i.neg;
      for (genvar l = 0; l < Lanes; l++) begin : g_init
        assign rem_in[l]  = {side_i.mag[l], UnitShift'(0)};
        assign quot_in[l] = '0;
      end
    end else begin : g_next
      assign vld_in  = vld_q[k-1];
      assign len_in  = len_q[k-1];
      assign neg_in  = neg_q[k-1];
      assign rem_in  = rem_q[k-1];
      assign quot_in = quot_q[k-1];
    end

    assign dsor = RemW'(len_in) << Bit;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= vld_in;
      end
    end

    // trial subtract per lane
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        len_q[k] <= len_in;
        neg_q[k] <= neg_in;
        for (int l = 0; l < Lanes; l++) begin
          if (rem_in[l] >= dsor) begin
            rem_q[k][l]  <= rem_in[l] - dsor;
            quot_q[k][l] <= quot_in[l] | (QuotW'(1) << Bit);
          end else begin
            rem_q[k][l]  <= rem_in[l];
            quot_q[k][l] <= quot_in[l];
          end
        end
      end
    end
  end

  assign valid_o = vld_q[QuotW-1];
  assign len_o   = len_q[QuotW-1];
  assign neg_o   = neg_q[QuotW-1];
  assign quot_o  = quot_q[QuotW-1];

endmodule
`default_nettype wire

// ===== rtl/vector3_normalize.sv =====
// top level of the 3d vector normalization pipeline
`default_nettype none
// Normalizes one signed Q7.8 vector per cycle while the output is not stalled:
// length = floor(sqrt(x^2+y^2+z^2)) at Q.8 scale and each unit component =
// trunc(c * 2^14 / length) in Q1.14; a zero vector gives zeros with was_zero set.
// The pipeline is 34 stages deep (squares, sum, 16 square root stages, 15 divider
// stages, output register), and a new transfer is taken every cycle unless the
// output stalls. A stall on the output freezes the whole pipeline.
module vector3_normalize (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire vnorm_pkg::vn_in_t in_data_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output vnorm_pkg::vn_out_t     out_data_o
);
  import vnorm_pkg::*;

  logic adv;
  logic [Lanes-1:0][CompW-1:0] comp;
  logic s1_vld_q, s2_vld_q, out_vld_q;
  vn_side_t s1_side_q, s2_side_q, sq_side;
  logic [Lanes-1:0][SumW-1:0] s1_sq_q;
  logic [SumW-1:0] s2_sum_q;
  logic sq_vld, dv_vld;
  logic [RootW-1:0] sq_root, dv_len;
  logic [Lanes-1:0] dv_neg;
  logic [Lanes-1:0][QuotW-1:0] dv_quot;
  logic [Lanes-1:0][CompW-1:0] unit;
  vn_out_t out_d, out_q;

  // whole pipeline moves unless a result is held
  assign adv        = !out_vld_q || out_ready_i;
  assign in_ready_o = adv;

  assign comp[0] = in_data_i.comp_x;
  assign comp[1] = in_data_i.comp_y;
  assign comp[2] = in_data_i.comp_z;

  // valid bits of the front and output stages
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      s2_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else if (adv) begin
      s1_vld_q  <= in_valid_i;
      s2_vld_q  <= s1_vld_q;
      out_vld_q <= dv_vld;
    end
  end

  // magnitudes, signs and squares
  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int l = 0; l < Lanes; l++) begin
        s1_side_q.neg[l] <= comp[l][CompW-1];
        s1_side_q.mag[l] <= comp[l][CompW-1] ? CompW'(-comp[l]) : comp[l];
        s1_sq_q[l]       <= SumW'($signed(comp[l]) * $signed(comp[l]));
      end
    end
  end

  // sum of squares
  always_ff @(posedge clk_i) begin
    if (adv) begin
      s2_side_q <= s1_side_q;
      s2_sum_q  <= s1_sq_q[0] + s1_sq_q[1] + s1_sq_q[2];
    end
  end

  vnorm_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (s2_vld_q),
    .sum_i   (s2_sum_q),
    .side_i  (s2_side_q),
    .valid_o (sq_vld),
    .root_o  (sq_root),
    .side_o  (sq_side)
  );

  vnorm_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (sq_vld),
    .len_i   (sq_root),
    .side_i  (sq_side),
    .valid_o (dv_vld),
    .len_o   (dv_len),
    .neg_o   (dv_neg),
    .quot_o  (dv_quot)
  );

  // sign restore, zero vector forced to zeros
  always_comb begin
    for (int l = 0; l < Lanes; l++) begin
      if (dv_len == '0) begin
        unit[l] = '0;
      end else if (dv_neg[l]) begin
        unit[l] = CompW'(-{1'b0, dv_quot[l]});
      end else begin
        unit[l] = CompW'(dv_quot[l]);
      end
    end
    out_d.length   = dv_len;
    out_d.unit_x   = unit[0];
    out_d.unit_y   = unit[1];
    out_d.unit_z   = unit[2];
    out_d.was_zero = dv_len == '0;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

`ifndef SYNTHESIS
  a_zero_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.was_zero |-> out_data_o.length == '0 &&
      out_data_o.unit_x == '0 && out_data_o.unit_y == '0 && out_data_o.unit_z == '0)
    else $error("zero vector result not cleared");
  a_unit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> $signed(out_data_o.unit_x) <= 16384 &&
      $signed(out_data_o.unit_x) >= -16384 && $signed(out_data_o.unit_y) <= 16384 &&
      $signed(out_data_o.unit_y) >= -16384 && $signed(out_data_o.unit_z) <= 16384 &&
      $signed(out_data_o.unit_z) >= -16384)
    else $error("unit component out of range");
  a_stall_freeze: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |=> $stable(s2_sum_q) && $stable(s1_vld_q))
    else $error("pipeline moved during stall");
`endif

endmodule
`default_nettype wire

// ===== tb/sv/tb_top.sv =====
// testbench for the vector normalization pipeline: scoreboard, stimulus and result checks
`timescale 1ns / 1ps
module tb_top;
  import vnorm_pkg::*;

  localparam int Latency   = 34;
  localparam int NumRandom = 1200;
  localparam longint CycleLimit = 400000;

  // scoreboard for normalized vectors
  class vnorm_scoreboard;
    vn_out_t pending_q[$];
    int      mismatches;

    function logic [15:0] unit_div(logic signed [15:0] c, longint len);
      longint mag;
      longint quo;
      mag = (c < 0) ? -longint'(c) : longint'(c);
      quo = (mag << UnitShift) / len;
      if (c < 0) quo = -quo;
      return quo[15:0];
    endfunction

    function longint isqrt(longint n);
      longint r;
      r = 0;
      for (int b = 17; b >= 0; b--) begin
        if ((r + (longint'(1) << b)) * (r + (longint'(1) << b)) <= n) r += longint'(1) << b;
      end
      return r;
    endfunction

    // note an accepted input vector
    function void note_input(vn_in_t v);
      vn_out_t e;
      longint sq;
      longint len;
      sq = longint'(v.comp_x) * v.comp_x + longint'(v.comp_y) * v.comp_y
         + longint'(v.comp_z) * v.comp_z;
      len = isqrt(sq);
      e = '0;
      if (len == 0) begin
        e.was_zero = 1'b1;
      end else begin
        e.length = len[15:0];
        e.unit_x = unit_div(v.comp_x, len);
        e.unit_y = unit_div(v.comp_y, len);
        e.unit_z = unit_div(v.comp_z, len);
      end
      pending_q.push_back(e);
    endfunction

    // check an accepted result against the oldest expectation
    function void check_result(vn_out_t got);
      vn_out_t e;
      if (pending_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", got);
        return;
      end
      e = pending_q.pop_front();
      if (got.length !== e.length || got.unit_x !== e.unit_x || got.unit_y !== e.unit_y ||
          got.unit_z !== e.unit_z || got.was_zero !== e.was_zero) begin
        mismatches++;
        if (mismatches <= 10) $display("result differs: expected %p actual %p", e, got);
      end
    endfunction
  endclass

  logic    clk_i;
  logic    rst_ni;
  logic    in_valid_i;
  logic    in_ready_o;
  vn_in_t  in_data_i;
  logic    out_valid_o;
  logic    out_ready_i;
  vn_out_t out_data_o;

  vnorm_scoreboard sb;
  longint cycles;
  bit     hold_off;

  vector3_normalize DUT (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .in_data_i,
    .out_valid_o, .out_ready_i, .out_data_o
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // transfer monitors
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && in_ready_o) sb.note_input(in_data_i);
    if (rst_ni && out_valid_o && out_ready_i) sb.check_result(out_data_o);
  end

  // cycle limit
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("vector3_normalize: mismatch");
      $finish;
    end
  end

  // receiver stall pattern with one or more long hold-offs
  initial begin
    int phase;
    out_ready_i = 1'b0;
    phase = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      phase++;
      if (hold_off) out_ready_i <= 1'b0;
      else if ((phase / 200) % 3 == 0) out_ready_i <= 1'b1;
      else out_ready_i <= ($urandom_range(0, 3) != 0);
    end
  end

  // drive one vector and wait for its transfer
  task automatic send_vector(logic [15:0] x, logic [15:0] y, logic [15:0] z);
    in_valid_i <= 1'b1;
    in_data_i  <= '{comp_x: x, comp_y: y, comp_z: z};
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic idle_gap(int n);
    in_valid_i <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  function automatic logic [15:0] rand_comp();
    case ($urandom_range(0, 5))
      0:       return 16'h8000;
      1:       return 16'h7fff;
      2:       return 16'($urandom_range(0, 15)) - 16'd8;
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin
    logic [15:0] corners [6];
    int sent;
    longint wait_cycles;
    sb = new();
    hold_off = 1'b0;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_data_i = '0;
    corners = '{16'h0000, 16'h0001, 16'hffff, 16'h7fff, 16'h8000, 16'h0100};
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: zero vector, axis corner values, all-max, all-min and two mixed vectors
    send_vector(16'h0000, 16'h0000, 16'h0000);
    for (int i = 1; i < 6; i++) begin
      send_vector(corners[i], 16'h0000, 16'h0000);
      send_vector(16'h0000, corners[i], 16'h0000);
      send_vector(16'h0000, 16'h0000, corners[i]);
    end
    send_vector(16'h8000, 16'h8000, 16'h8000);
    send_vector(16'h7fff, 16'h7fff, 16'h7fff);
    send_vector(16'h8000, 16'h7fff, 16'h0001);
    send_vector(16'h0001, 16'hffff, 16'h0001);

    // random bursts; long receiver hold-off part way through
    sent = 0;
    while (sent < NumRandom) begin
      int burst;
      burst = $urandom_range(1, 40);
      if (sent >= 400 && sent < 440) begin
        hold_off = 1'b1;
        fork
          begin
            repeat (150) @(posedge clk_i);
            hold_off = 1'b0;
          end
        join_none
      end
      for (int k = 0; k < burst && sent < NumRandom; k++) begin
        send_vector(rand_comp(), rand_comp(), rand_comp());
        sent++;
      end
      if ($urandom_range(0, 2) != 0) idle_gap($urandom_range(1, 12));
    end
    in_valid_i <= 1'b0;

    // drain
    wait_cycles = 0;
    while (sb.pending_q.size() != 0 && wait_cycles < 100000) begin
      @(posedge clk_i);
      wait_cycles++;
    end
    repeat (Latency + 10) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.pending_q.size() == 0) begin
      $display("vector3_normalize: match");
    end else begin
      $display("vector3_normalize: mismatch");
    end
    $finish;
  end
endmodule

// ===== vector3_normalize.f =====
rtl/vnorm_pkg.sv
rtl/vnorm_sqrt.sv
rtl/vnorm_div.sv
rtl/vector3_normalize.sv
tb/sv/tb_top.sv
